/* design/sacl_pkg.sv */
// Package for the set-associative LRU cache: command codes, controller states
// and the command and status structs between controller and datapath.
// Depends on nothing.
`default_nettype none
package sacl_pkg;

  // Command codes of an input transfer; the fourth code is unused.
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_STORE = 2'd1,
    CMD_FILL  = 2'd2
  } cmd_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_VICTIM,
    ST_FILL
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic hit_upd;
    logic start_scan;
    logic scan_step;
    logic emit_miss;
    logic fill_wr;
    logic clr_step;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic scan_done;
    logic fill_last;
    logic clr_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* design/set_assoc_cache_lru.sv */
// Set-associative LRU cache. An accepted access reads the tag, stamp and word
// rows of its set into registers; a hit then compares and writes back.
// A miss then scans for the victim before the fill request, the victim scan
// visiting one stamp per cycle. The last fill word completes the access.
// After reset a clearing pass zeroes the stamp rows, one set per cycle,
// during which no transfer is accepted.
`default_nettype none
module set_assoc_cache_lru #(
  parameter int SETS       = 64,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 32,
  parameter int ADDR_BITS  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      read_data_o,
  output logic             hit_o,
  output logic             fill_request_o,
  output logic [31:0]      fill_address_o,
  output logic             done_res_o
);
  import sacl_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // Controller.
  sacl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .ctl_o      (ctl)
  );

  // Datapath.
  sacl_dpath #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .address_i      (address_i),
    .data_i         (data_i),
    .command_i      (command_i),
    .out_stall_i    (out_stall_i),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .read_data_o    (read_data_o),
    .hit_o          (hit_o),
    .fill_request_o (fill_request_o),
    .fill_address_o (fill_address_o),
    .done_res_o     (done_res_o)
  );

endmodule
`default_nettype wire

/* design/sacl_ctrl.sv */
// Controller state machine of the set-associative LRU cache.
// Depends on sacl_pkg.
`default_nettype none
module sacl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    command_i,
  input  wire sacl_pkg::sts_t sts_i,
  output logic               in_stall_o,
  output sacl_pkg::ctl_t     ctl_o
);
  import sacl_pkg::*;

  state_e state_q, state_d;
  logic   acc;
  logic   is_access;
  logic   is_fill;

  assign acc       = in_valid_i && !in_stall_o;
  assign is_access = (command_i == CMD_LOAD) || (command_i == CMD_STORE);
  assign is_fill   = (command_i == CMD_FILL);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc && is_access) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (!sts_i.hit) state_d = ST_VICTIM;
        else if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_VICTIM: begin
        if (sts_i.scan_done && sts_i.out_free) state_d = ST_FILL;
      end
      ST_FILL: begin
        if (acc && is_fill && sts_i.fill_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        ctl_o.clr_step = 1'b1;
      end
      ST_IDLE: begin
        in_stall_o    = !sts_i.out_free;
        ctl_o.capture = acc && is_access;
      end
      ST_LOOKUP: begin
        ctl_o.hit_upd    = sts_i.hit && sts_i.out_free;
        ctl_o.start_scan = !sts_i.hit;
      end
      ST_VICTIM: begin
        ctl_o.scan_step = !sts_i.scan_done;
        ctl_o.emit_miss = sts_i.scan_done && sts_i.out_free;
      end
      ST_FILL: begin
        in_stall_o    = !sts_i.out_free;
        ctl_o.fill_wr = acc && is_fill;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/sacl_dpath.sv */
// Datapath of the set-associative LRU cache: tag, stamp and word memories,
// pending access registers, victim scan, use counter and result register.
// Depends on sacl_pkg.
`default_nettype none
module sacl_dpath #(
  parameter int SETS       = 64,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 32,
  parameter int ADDR_BITS  = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [31:0]    address_i,
  input  wire logic [31:0]    data_i,
  input  wire logic [1:0]     command_i,
  input  wire logic           out_stall_i,
  input  wire sacl_pkg::ctl_t ctl_i,
  output sacl_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  output logic [31:0]         read_data_o,
  output logic                hit_o,
  output logic                fill_request_o,
  output logic [31:0]         fill_address_o,
  output logic                done_res_o
);
  import sacl_pkg::*;

  localparam int OFF    = $clog2(LINE_BYTES + 1) - 1;
  localparam int SETB   = $clog2(SETS + 1) - 1;
  localparam int WOFF   = OFF - 2;
  localparam int WPL    = 2 ** WOFF;
  localparam int SW     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WIW    = (WOFF > 0) ? WOFF : 1;
  localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW     = $clog2(WAYS + 1);
  localparam int TS     = OFF + SETB;
  localparam int TW     = 32 - TS;
  localparam int WDEPTH = SETS * WPL;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam logic [31:0] OFFMASK = 32'((64'd1 << OFF) - 64'd1);
  localparam logic [31:0] SETMASK = 32'((64'd1 << SETB) - 64'd1);
  localparam logic [31:0] AMASK   = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                    32'((64'd1 << ADDR_BITS) - 64'd1);

  // Memories, one row per set (tags, stamps) or per set and word (data).
  logic [WAYS-1:0][TW-1:0] tag_mem   [SETS];
  logic [WAYS-1:0][31:0]   stamp_mem [SETS];
  logic [WAYS-1:0][31:0]   word_mem  [WDEPTH];

  logic [WAYS-1:0][TW-1:0] tag_row_q;
  logic [WAYS-1:0][31:0]   stamp_row_q;
  logic [WAYS-1:0][31:0]   word_row_q;

  // Pending access.
  logic [31:0]   addr_q;
  logic [31:0]   sdata_q;
  logic          store_q;
  logic [SW-1:0] set_q;
  logic [WIW-1:0] widx_q;
  logic [TW-1:0] tag_q;

  logic [31:0]    cnt_q;
  logic [31:0]    cnt_inc;
  logic [SW-1:0]  clr_q;
  logic [WIW-1:0] fcnt_q;
  logic [31:0]    ld_word_q;
  logic [CW-1:0]  scan_q;
  logic [WW-1:0]  best_q;
  logic [31:0]    bstamp_q;

  logic [SW-1:0]  set_in;
  logic [WIW-1:0] widx_in;
  logic [TW-1:0]  tag_in;
  logic [WAW-1:0] raddr;
  logic [WAW-1:0] hit_waddr;
  logic [WAW-1:0] fill_waddr;
  logic [WAYS-1:0] match;
  logic [WW-1:0]  hit_way;
  logic           fill_sel;
  logic [31:0]    fill_word;
  logic           fill_done;
  logic [31:0]    scan_stamp;

  logic        out_valid_q;
  logic [31:0] rd_q;
  logic        hit_q;
  logic        fr_q;
  logic [31:0] fa_q;
  logic        dn_q;
  logic        emit;

  // Address split of the incoming transfer.
  assign set_in  = SW'((address_i >> OFF) & SETMASK);
  assign widx_in = WIW'((address_i & OFFMASK) >> 2);
  assign tag_in  = TW'((address_i & AMASK) >> TS);
  assign raddr   = (WAW'(set_in) << WOFF) | WAW'(widx_in);
  assign hit_waddr  = (WAW'(set_q) << WOFF) | WAW'(widx_q);
  assign fill_waddr = (WAW'(set_q) << WOFF) | WAW'(fcnt_q);
  assign cnt_inc = cnt_q + 32'd1;

  // Tag compare over the ways, lowest matching way wins.
  always_comb begin
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      match[w] = (stamp_row_q[w] != 32'd0) && (tag_row_q[w] == tag_q);
      if (match[w]) hit_way = WW'(w);
    end
  end

  assign fill_sel   = (fcnt_q == widx_q);
  assign fill_word  = (store_q && fill_sel) ? sdata_q : data_i;
  assign fill_done  = ctl_i.fill_wr && sts_o.fill_last;
  assign scan_stamp = stamp_row_q[scan_q[WW-1:0]];

  assign sts_o.hit       = |match;
  assign sts_o.scan_done = (scan_q == CW'(WAYS));
  assign sts_o.fill_last = (fcnt_q == WIW'(WPL - 1));
  assign sts_o.clr_done  = (clr_q == SW'(SETS - 1));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // Memory reads at capture, writes on hit, fill and clearing.
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      tag_row_q   <= tag_mem[set_in];
      stamp_row_q <= stamp_mem[set_in];
      word_row_q  <= word_mem[raddr];
    end
    if (ctl_i.clr_step) begin
      stamp_mem[clr_q] <= '0;
    end
    if (ctl_i.hit_upd) begin
      stamp_mem[set_q][hit_way] <= cnt_inc;
      if (store_q) word_mem[hit_waddr][hit_way] <= sdata_q;
    end
    if (ctl_i.fill_wr) begin
      word_mem[fill_waddr][best_q] <= fill_word;
    end
    if (fill_done) begin
      tag_mem[set_q][best_q]   <= tag_q;
      stamp_mem[set_q][best_q] <= cnt_inc;
    end
  end

  // Pending access capture and fill word for a load.
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      addr_q  <= address_i;
      sdata_q <= data_i;
      store_q <= (command_i == CMD_STORE);
      set_q   <= set_in;
      widx_q  <= widx_in;
      tag_q   <= tag_in;
    end
    if (ctl_i.fill_wr && fill_sel) ld_word_q <= data_i;
  end

  // Victim scan, one way per cycle.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start_scan) begin
      best_q   <= '0;
      bstamp_q <= stamp_row_q[0];
      scan_q   <= CW'(1);
    end else if (ctl_i.scan_step) begin
      if (scan_stamp < bstamp_q) begin
        best_q   <= scan_q[WW-1:0];
        bstamp_q <= scan_stamp;
      end
      scan_q <= scan_q + CW'(1);
    end
  end

  // Use counter, fill counter and clearing counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      fcnt_q <= '0;
      clr_q  <= '0;
    end else begin
      if (ctl_i.hit_upd || fill_done) cnt_q <= cnt_inc;
      if (ctl_i.emit_miss || fill_done) fcnt_q <= '0;
      else if (ctl_i.fill_wr) fcnt_q <= fcnt_q + WIW'(1);
      if (ctl_i.clr_step && !sts_o.clr_done) clr_q <= clr_q + SW'(1);
    end
  end

  // Result register.
  assign emit = ctl_i.hit_upd || ctl_i.emit_miss || fill_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.hit_upd) begin
      rd_q  <= store_q ? 32'd0 : word_row_q[hit_way];
      hit_q <= 1'b1;
      fr_q  <= 1'b0;
      fa_q  <= 32'd0;
      dn_q  <= 1'b1;
    end else if (ctl_i.emit_miss) begin
      rd_q  <= 32'd0;
      hit_q <= 1'b0;
      fr_q  <= 1'b1;
      fa_q  <= addr_q & ~OFFMASK;
      dn_q  <= 1'b0;
    end else if (fill_done) begin
      rd_q  <= store_q ? 32'd0 : (fill_sel ? data_i : ld_word_q);
      hit_q <= 1'b0;
      fr_q  <= 1'b0;
      fa_q  <= 32'd0;
      dn_q  <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = rd_q;
  assign hit_o          = hit_q;
  assign fill_request_o = fr_q;
  assign fill_address_o = fa_q;
  assign done_res_o     = dn_q;

endmodule
`default_nettype wire

/* design/sacl_checker.sv */
// Port-level checks for the set-associative LRU cache, and the bind that
// attaches them to the top level. Depends on set_assoc_cache_lru.
`default_nettype none
module sacl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        hit_o,
  input wire logic        fill_request_o,
  input wire logic [31:0] fill_address_o,
  input wire logic        done_res_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A hit is always a completed access.
  a_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> done_res_o && !fill_request_o)
    else $error("hit without completion");

  // A fill request never completes the access and is word aligned.
  a_fill_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fill_request_o |-> !done_res_o && fill_address_o[1:0] == 2'd0)
    else $error("malformed fill request");

  // Every result either completes or requests a fill.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> done_res_o || fill_request_o)
    else $error("result of no kind");

endmodule

bind set_assoc_cache_lru sacl_checker u_sacl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .hit_o          (hit_o),
  .fill_request_o (fill_request_o),
  .fill_address_o (fill_address_o),
  .done_res_o     (done_res_o)
);
`default_nettype wire

/* tb/tb_set_assoc_cache_lru.sv */
// Self-checking bench for the set-associative LRU cache: loads, stores and fill
// words go in, and each hit, fill request and completion is checked against a behavioral cache.
// Depends on sacl_pkg and set_assoc_cache_lru.
`default_nettype none

module tb_set_assoc_cache_lru;
  timeunit 1ns;
  timeprecision 1ps;
  import sacl_pkg::*;

  localparam int NSETS = 64;
  localparam int NWAYS = 4;
  localparam int WORDS = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  // One result transfer as seen on the output ports.
  typedef struct packed {
    logic [31:0] read_data;
    logic        hit;
    logic        fill_request;
    logic [31:0] fill_address;
    logic        done_res;
  } result_t;

  // Tracks expected results and compares accepted results against them.
  class cache_scoreboard;
    result_t pending_results[$];
    int      errors;
    int      checked;

    function void note_input(result_t r);
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result rd=%h hit=%b fr=%b fa=%h done=%b", $time,
                 got.read_data, got.hit, got.fill_request, got.fill_address, got.done_res);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.read_data !== want.read_data) begin
        $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                 got.read_data);
        errors++;
      end
      if (got.hit !== want.hit) begin
        $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
        errors++;
      end
      if (got.fill_request !== want.fill_request) begin
        $display("%0t: fill_request expected %b actual %b", $time, want.fill_request,
                 got.fill_request);
        errors++;
      end
      if (got.fill_address !== want.fill_address) begin
        $display("%0t: fill_address expected %h actual %h", $time, want.fill_address,
                 got.fill_address);
        errors++;
      end
      if (got.done_res !== want.done_res) begin
        $display("%0t: done_res expected %b actual %b", $time, want.done_res,
                 got.done_res);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  command_i;
  logic [31:0] address_i;
  logic [31:0] data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] read_data_o;
  logic        hit_o;
  logic        fill_request_o;
  logic [31:0] fill_address_o;
  logic        done_res_o;

  set_assoc_cache_lru u_dut (.*);

  cache_scoreboard scb;

  // Shadow cache state.
  logic [20:0] tags_q   [NSETS*NWAYS];
  logic [31:0] stamps_q [NSETS*NWAYS];
  logic [31:0] words_q  [NSETS*NWAYS*WORDS];
  logic [31:0] use_count;
  logic        miss_is_store;
  logic [31:0] miss_addr;
  logic [31:0] miss_store_word;
  int          victim;
  int          fill_idx;
  logic        fill_wait;

  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_cycles;
  int idle_count;
  int n_hits, n_misses;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Computes the cache's response to one accepted transfer.
  function automatic void predict_cache(logic [1:0] cmd, logic [31:0] addr,
                                        logic [31:0] data);
    result_t r;
    int s, line, best;
    logic [20:0] t;
    r = '0;
    if (cmd == CMD_FILL) begin
      if (!fill_wait) return;
      line = int'(miss_addr[10:5]) * NWAYS + victim;
      words_q[line*WORDS + fill_idx] = data;
      if (fill_idx + 1 < WORDS) begin
        fill_idx++;
        return;
      end
      fill_idx  = 0;
      fill_wait = 1'b0;
      tags_q[line] = miss_addr[31:11];
      use_count++;
      stamps_q[line] = use_count;
      if (miss_is_store) words_q[line*WORDS + miss_addr[4:2]] = miss_store_word;
      else r.read_data = words_q[line*WORDS + miss_addr[4:2]];
      r.done_res = 1'b1;
      scb.note_input(r);
      return;
    end
    if (cmd != CMD_LOAD && cmd != CMD_STORE) return;
    if (fill_wait) return;
    s = int'(addr[10:5]);
    t = addr[31:11];
    for (int w = 0; w < NWAYS; w++) begin
      line = s * NWAYS + w;
      if (stamps_q[line] != 0 && tags_q[line] == t) begin
        use_count++;
        stamps_q[line] = use_count;
        if (cmd == CMD_STORE) words_q[line*WORDS + addr[4:2]] = data;
        else r.read_data = words_q[line*WORDS + addr[4:2]];
        r.hit = 1'b1;
        r.done_res = 1'b1;
        n_hits++;
        scb.note_input(r);
        return;
      end
    end
    best = 0;
    for (int w = 1; w < NWAYS; w++)
      if (stamps_q[s*NWAYS + w] < stamps_q[s*NWAYS + best]) best = w;
    victim          = best;
    miss_is_store   = (cmd == CMD_STORE);
    miss_addr       = addr;
    miss_store_word = data;
    fill_idx        = 0;
    fill_wait       = 1'b1;
    r.fill_request  = 1'b1;
    r.fill_address  = {addr[31:5], 5'd0};
    n_misses++;
    scb.note_input(r);
  endfunction

  // Offers one transfer, with an optional random gap, until it is accepted.
  task automatic send_item(logic [1:0] cmd, logic [31:0] addr, logic [31:0] data);
    while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    address_i  <= addr;
    data_i     <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_cache(cmd, addr, data);
  endtask

  // Sends a full line of random fill words.
  task automatic send_line();
    for (int i = 0; i < WORDS; i++) send_item(CMD_FILL, $urandom, $urandom);
  endtask

  // Access plus fill when it misses, leaving the shadow state idle.
  task automatic access(logic [1:0] cmd, logic [31:0] addr, logic [31:0] data);
    send_item(cmd, addr, data);
    if (fill_wait) send_line();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (scb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Address drawn mostly from a few tags in a few sets to get hits and evictions.
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(9) < 8) begin
      a[31:11] = 21'($urandom_range(5));
      a[10:5]  = 6'($urandom_range(3));
      if ($urandom_range(9) == 0) a[31:11] = ~21'($urandom_range(5));
    end
    return a;
  endfunction

  // Receiver: stalls at random, and once holds off for a long stretch.
  initial begin
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= (rcv_idle_pct > 0 && $urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // Result monitor and watchdog on accepted transfers.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (out_valid_o && !out_stall_i)
        scb.check_result({read_data_o, hit_o, fill_request_o, fill_address_o, done_res_o});
    end
  end

  initial begin
    wait (idle_count >= WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [31:0] a;
    int r;
    scb = new();
    foreach (stamps_q[i]) begin
      stamps_q[i] = '0;
      tags_q[i] = '0;
    end
    foreach (words_q[i]) words_q[i] = '0;
    use_count = '0; fill_wait = 1'b0; fill_idx = 0; victim = 0;
    miss_is_store = 1'b0; miss_addr = '0; miss_store_word = '0;
    snd_idle_pct = 0; rcv_idle_pct = 0; hold_cycles = 0; idle_count = 0;
    n_hits = 0; n_misses = 0;
    rst_ni = 1'b0; in_valid_i = 1'b0; command_i = CMD_LOAD;
    address_i = '0; data_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: stray fill, unused code, miss, fills, hits, all-ones address.
    send_item(CMD_FILL, 32'h0, 32'hFFFF_FFFF);
    send_item(2'd3, 32'hFFFF_FFFF, 32'h1234_5678);
    send_item(CMD_LOAD, 32'h0000_0003, 32'h0);
    send_item(CMD_STORE, 32'h0000_0040, 32'h5);   // ignored while a fill is awaited
    send_item(2'd3, 32'h0, 32'h0);
    send_line();
    access(CMD_LOAD, 32'h0000_0001, 32'h0);
    access(CMD_STORE, 32'h0000_001E, 32'hFFFF_FFFF);
    access(CMD_LOAD, 32'h0000_001C, 32'h0);
    access(CMD_STORE, 32'hFFFF_FFFC, 32'h0);
    access(CMD_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Five tags in set 0 force an LRU eviction.
    for (int k = 1; k <= 5; k++) access(CMD_LOAD, {21'(k), 11'd4}, 32'h0);
    access(CMD_LOAD, 32'h0000_0004, 32'h0);
    drain();

    // Random phases with different idling, and one long receiver hold-off.
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 47 : 0;
      rcv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 12 : 0;
      if (ph == 2) hold_cycles = 300;
      for (int i = 0; i < 80; i++) begin
        r = $urandom_range(99);
        a = pick_addr();
        if (r < 85) access(($urandom_range(1) != 0) ? CMD_STORE : CMD_LOAD, a, $urandom);
        else if (r < 92) send_item(CMD_FILL, $urandom, $urandom);
        else if (r < 96) send_item(2'd3, a, $urandom);
        else begin
          send_item(CMD_LOAD, a, $urandom);
          send_item(CMD_STORE, pick_addr(), $urandom);  // dropped if a fill is awaited
          if (fill_wait) send_line();
        end
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    $display("Covered %0d checked results: %0d hits, %0d misses with line fills,",
             scb.checked, n_hits, n_misses);
    $display("stray fills, unused codes and accesses during fills, under varied stalls.");
    if (scb.errors == 0 && scb.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* files.f */
design/sacl_pkg.sv
design/sacl_ctrl.sv
design/sacl_dpath.sv
design/set_assoc_cache_lru.sv
design/sacl_checker.sv
tb/tb_set_assoc_cache_lru.sv
